FILE: rtl/core/b64e_pkg.sv
// Shared types and constants for the base64 stream encoder.
// Holds the alphabet mapping, the pad code and the job word passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam int unsigned JOBQ_DEPTH_DEF = 2;
    localparam int unsigned CHAR_W         = 7;
    localparam int unsigned SEXTET_W       = 6;
    localparam int unsigned MAX_CHARS      = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef logic [CHAR_W-1:0] char_t;

    // One encoded byte: up to four characters and the index of the last one.
    typedef struct packed {
        char_t [MAX_CHARS-1:0] chars;
        logic  [1:0]           last_idx;
        logic                  fin;
    } job_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic char_t b64_sym(input logic [SEXTET_W-1:0] v);
        char_t w;
        w = {1'b0, v};
        if (v < 6'd26)
            return w + 7'd65;
        else if (v < 6'd52)
            return w + 7'd71;
        else if (v < 6'd62)
            return w - 7'd4;
        else if (v == 6'd62)
            return 7'd43;
        else
            return 7'd47;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64e_front.sv
// Front end: accepts bytes, tracks group phase and carry bits, builds job words.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 take,
    input  wire [7:0]           data_byte,
    input  wire                 final_byte,
    output b64e_pkg::job_t      job
);
    import b64e_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    always_comb
    begin
        job.fin      = final_byte;
        job.chars[2] = PAD_CHAR;
        job.chars[3] = PAD_CHAR;
        unique case (phase_reg)
            PH_SECOND:
            begin
                job.chars[0] = b64_sym({carry_reg[1:0], data_byte[7:4]});
                job.chars[1] = b64_sym({data_byte[3:0], 2'b00});
                job.last_idx = final_byte ? 2'd2 : 2'd0;
                carry_next   = data_byte[3:0];
                phase_next   = PH_THIRD;
            end
            PH_THIRD:
            begin
                job.chars[0] = b64_sym({carry_reg, data_byte[7:6]});
                job.chars[1] = b64_sym(data_byte[5:0]);
                job.last_idx = 2'd1;
                carry_next   = 4'd0;
                phase_next   = PH_FIRST;
            end
            default:
            begin
                // first byte of a group; the unused phase code lands here too
                job.chars[0] = b64_sym(data_byte[7:2]);
                job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
                job.last_idx = final_byte ? 2'd3 : 2'd0;
                carry_next   = {2'b00, data_byte[1:0]};
                phase_next   = PH_SECOND;
            end
        endcase
        if (final_byte)
        begin
            carry_next = 4'd0;
            phase_next = PH_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            carry_reg <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/b64e_jobq.sv
// Short job queue between front and back ends.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_jobq
#(
    parameter int unsigned DEPTH = b64e_pkg::JOBQ_DEPTH_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_en,
    input  b64e_pkg::job_t      wr_job,
    output logic                full,
    input  wire                 rd_en,
    output logic                rd_valid,
    output b64e_pkg::job_t      rd_job
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

FILE: rtl/core/b64e_back.sv
// Back end: walks each job one character per cycle into the output register when it is free or popped.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     job_valid,
    input  b64e_pkg::job_t          job,
    output logic                    job_done,
    input  wire                     pop,
    output logic                    empty,
    output b64e_pkg::char_t         out_char,
    output logic                    run_end,
    output logic                    message_end
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    char_t      char_reg;
    logic       run_end_reg, msg_end_reg;
    logic       load, at_last;

    assign at_last  = (idx_reg == job.last_idx);
    // advance when the output word is free or being taken this cycle
    assign load     = job_valid && (!out_valid_reg || pop);
    assign job_done = load && at_last;

    assign empty       = !out_valid_reg;
    assign out_char    = char_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= at_last ? 2'd0 : idx_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg    <= job.chars[idx_reg];
            run_end_reg <= at_last;
            msg_end_reg <= at_last && job.fin;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_encoder.sv
// Base64 stream encoder (standard alphabet, '=' padding), one byte per word in.
// A byte's job word is written into the job queue, then loaded into the back end's output register.
// Throughput: one character per cycle from the back end's output register while it
// is free or popped; a byte is taken every cycle while the job queue has room, so
// mid-message a byte yields 4/3 characters on average and a final byte up to 4.
// Reset: async active low; clears phase, carry, queue and output; no clearing pass.
// Depends on b64e_pkg, b64e_front, b64e_jobq, b64e_back.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
#(
    parameter int unsigned JOBQ_DEPTH = b64e_pkg::JOBQ_DEPTH_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  data_byte,
    input  wire        final_byte,
    output logic       empty,
    input  wire        pop,
    output logic [6:0] out_char,
    output logic       run_end,
    output logic       message_end
);
    import b64e_pkg::*;

    job_t front_job, q_job;
    logic take, q_valid, q_pop;

    assign take = push && !full;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .job        (front_job)
    );

    b64e_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (q_job),
        .job_done    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .run_end     (run_end),
        .message_end (message_end)
    );

endmodule

`default_nettype wire
